### src/bpfa_pkg.sv
// shared types, constants and helpers of the bitmap page frame allocator
package bpfa_pkg;

  localparam int AREAS          = 2;
  localparam int AREA_W         = 1;
  localparam int AREA_CNT_W     = 2;
  localparam int PAGES_PER_AREA = 4096;
  localparam int PAGE_BYTES     = 4096;
  localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
  localparam int PAGES_W        = 13;
  localparam int PIDX_W         = $clog2(PAGES_PER_AREA);
  localparam int ADDR_W         = 48;
  localparam int CMD_W          = 2;
  localparam int STATUS_W       = 2;
  localparam int WORD_BITS      = 32;
  localparam int BIT_W          = $clog2(WORD_BITS);
  localparam int WORDS_PER_AREA = PAGES_PER_AREA / WORD_BITS;
  localparam int WORD_W         = $clog2(WORDS_PER_AREA);
  localparam int NWORD_W        = WORD_W + 1;
  localparam int MEM_DEPTH      = AREAS * WORDS_PER_AREA;
  localparam int MEM_AW         = AREA_W + WORD_W;
  localparam int MIN_AREA_PAGES = 4;
  localparam int PAGE_GROUP_W   = 3;
  localparam int APB_DW         = 64;
  localparam int APB_AW         = 6;
  localparam int REG_IDX_W      = 3;

  localparam logic [REG_IDX_W-1:0] REG_AREA_COUNT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_AREA0_BASE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_AREA0_PAGES = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_AREA1_BASE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_AREA1_PAGES = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_MARK = 2'd0,
    CMD_FREE = 2'd1,
    CMD_FIND = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_FOUND   = 2'd2,
    ST_NONE    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD_CHK,
    S_UPD_WR,
    S_SCAN,
    S_FOUND_ADDR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [AREA_CNT_W-1:0]            area_count;
    logic [AREAS-1:0][ADDR_W-1:0]     base;
    logic [AREAS-1:0][PAGES_W-1:0]    pages;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic upd_chk;
    logic upd_wr;
    logic upd_next;
    logic scan_step;
    logic set_res_upd;
    logic set_res_none;
    logic calc_addr;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_find;
    logic area_hit;
    logic area_last;
    logic scan_found;
    logic scan_end;
    logic out_free;
  } dp_status_t;

  function automatic logic [PAGES_W-1:0] usable_pages(input logic [PAGES_W-1:0] pages);
    logic [PAGES_W-1:0] u;
    if (pages < PAGES_W'(MIN_AREA_PAGES)) begin
      u = '0;
    end else begin
      u = {pages[PAGES_W-1:PAGE_GROUP_W], PAGE_GROUP_W'(0)};
    end
    return u;
  endfunction

  function automatic logic [NWORD_W-1:0] word_count(input logic [PAGES_W-1:0] u);
    return NWORD_W'(u[PAGES_W-1:BIT_W]) + NWORD_W'(|u[BIT_W-1:0]);
  endfunction

endpackage

### src/bpfa_if.sv
// request and response channel interfaces of the allocator
interface bpfa_req_if;
  import bpfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] addr;
  modport source (output valid, cmd, addr, input ready);
  modport sink (input valid, cmd, addr, output ready);
endinterface

interface bpfa_rsp_if;
  import bpfa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   page_addr;
  modport source (output valid, status, page_addr, input ready);
  modport sink (input valid, status, page_addr, output ready);
endinterface

### src/bpfa_regs.sv
// apb configuration registers: area count, area bases and page counts
module bpfa_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpfa_pkg::APB_AW-1:0]  paddr,
  input  logic [bpfa_pkg::APB_DW-1:0]  pwdata,
  output logic [bpfa_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output bpfa_pkg::cfg_t               cfg
);
  import bpfa_pkg::*;

  cfg_t                 cfg_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;
  logic [PAGES_W-1:0]   wr_pages;
  logic [PAGES_W-1:0]   sat_pages;

  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite;
  assign idx       = paddr[APB_AW-1:APB_AW-REG_IDX_W];
  assign wr_pages  = pwdata[PAGES_W-1:0];
  assign sat_pages = (wr_pages > PAGES_W'(PAGES_PER_AREA)) ? PAGES_W'(PAGES_PER_AREA) : wr_pages;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_AREA_COUNT:  cfg_r.area_count <= pwdata[AREA_CNT_W-1:0];
        REG_AREA0_BASE:  cfg_r.base[0]    <= pwdata[ADDR_W-1:0];
        REG_AREA0_PAGES: cfg_r.pages[0]   <= sat_pages;
        REG_AREA1_BASE:  cfg_r.base[1]    <= pwdata[ADDR_W-1:0];
        REG_AREA1_PAGES: cfg_r.pages[1]   <= sat_pages;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AREA_COUNT:  prdata = APB_DW'(cfg_r.area_count);
      REG_AREA0_BASE:  prdata = APB_DW'(cfg_r.base[0]);
      REG_AREA0_PAGES: prdata = APB_DW'(cfg_r.pages[0]);
      REG_AREA1_BASE:  prdata = APB_DW'(cfg_r.base[1]);
      REG_AREA1_PAGES: prdata = APB_DW'(cfg_r.pages[1]);
      default:         prdata = '0;
    endcase
  end

endmodule

### src/bpfa_ctrl.sv
// controller state machine sequencing updates, scans and result transfers
module bpfa_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bpfa_pkg::dp_status_t   st,
  output bpfa_pkg::ctrl_cmd_t    cmd
);
  import bpfa_pkg::*;

  state_e state_r;
  state_e state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = st.in_find ? S_SCAN : S_UPD_CHK;
        end
      end
      S_UPD_CHK: begin
        if (st.area_hit) begin
          state_nxt = S_UPD_WR;
        end else if (st.area_last) begin
          state_nxt = S_DONE;
        end
      end
      S_UPD_WR: begin
        state_nxt = st.area_last ? S_DONE : S_UPD_CHK;
      end
      S_SCAN: begin
        if (st.scan_found) begin
          state_nxt = S_FOUND_ADDR;
        end else if (st.scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_FOUND_ADDR: state_nxt = S_DONE;
      S_DONE: begin
        if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_UPD_CHK: begin
        cmd.upd_chk = 1'b1;
        if (!st.area_hit) begin
          cmd.set_res_upd = st.area_last;
          cmd.upd_next    = !st.area_last;
        end
      end
      S_UPD_WR: begin
        cmd.upd_wr      = 1'b1;
        cmd.set_res_upd = st.area_last;
        cmd.upd_next    = !st.area_last;
      end
      S_SCAN: begin
        cmd.scan_step    = 1'b1;
        cmd.set_res_none = !st.scan_found && st.scan_end;
      end
      S_FOUND_ADDR: cmd.calc_addr = 1'b1;
      S_DONE:       cmd.load_out  = st.out_free;
      default: ;
    endcase
  end

endmodule

### src/bpfa_dp.sv
// datapath: used-page bitmap memory, area range checks, word scan and result registers
module bpfa_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bpfa_pkg::cfg_t                 cfg,
  input  logic [bpfa_pkg::CMD_W-1:0]     in_cmd,
  input  logic [bpfa_pkg::ADDR_W-1:0]    in_addr,
  input  bpfa_pkg::ctrl_cmd_t            cmd,
  output bpfa_pkg::dp_status_t           st,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bpfa_pkg::STATUS_W-1:0]  out_status,
  output logic [bpfa_pkg::ADDR_W-1:0]    out_page_addr
);
  import bpfa_pkg::*;

  logic [WORD_BITS-1:0]            mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]            vld_r;
  logic [WORD_BITS-1:0]            mem_q_r;
  logic                            q_vld_r;

  logic [AREA_CNT_W-1:0]           live;
  logic [AREAS-1:0][PAGES_W-1:0]   usable;

  logic [ADDR_W-1:0]               addr_r;
  logic                            mark_r;
  logic [AREA_W-1:0]               area_r;
  logic                            hit_r;
  logic [PIDX_W-1:0]               upd_idx_r;

  logic [ADDR_W-1:0]               lo;
  logic [ADDR_W:0]                 hi;
  logic [ADDR_W-1:0]               diff;
  logic [PIDX_W-1:0]               chk_idx;
  logic                            area_hit;

  logic [AREA_CNT_W-1:0]           scan_area_r;
  logic [NWORD_W-1:0]              scan_word_r;
  logic                            pend_r;
  logic [AREA_W-1:0]               pend_area_r;
  logic [WORD_W-1:0]               pend_word_r;
  logic [WORD_BITS-1:0]            pend_mask_r;
  logic                            scan_live;
  logic [AREA_W-1:0]               sa;
  logic [PAGES_W-1:0]              su;
  logic                            scan_issue;
  logic [PAGES_W-1:0]              rem;
  logic [WORD_BITS-1:0]            issue_mask;
  logic [WORD_BITS-1:0]            q_eff;
  logic [WORD_BITS-1:0]            free_vec;
  logic [BIT_W-1:0]                ffs;
  logic                            scan_found;

  logic [AREA_W-1:0]               found_area_r;
  logic [PIDX_W-1:0]               found_idx_r;

  logic                            rd_en;
  logic [MEM_AW-1:0]               rd_addr;
  logic                            wr_en;
  logic [MEM_AW-1:0]               wr_addr;
  logic [WORD_BITS-1:0]            wdata;

  status_e                         res_status_r;
  logic [ADDR_W-1:0]               res_addr_r;
  logic                            out_valid_r;
  status_e                         out_status_r;
  logic [ADDR_W-1:0]               out_addr_r;

  assign live = (cfg.area_count > AREA_CNT_W'(AREAS)) ? AREA_CNT_W'(AREAS) : cfg.area_count;

  always_comb begin
    for (int a = 0; a < AREAS; a++) begin
      usable[a] = usable_pages(cfg.pages[a]);
    end
  end

  // range check of the current area for mark and free
  assign lo       = cfg.base[area_r];
  assign hi       = (ADDR_W+1)'(lo) + (ADDR_W+1)'({usable[area_r], PAGE_SHIFT'(0)});
  assign diff     = addr_r - lo;
  assign chk_idx  = diff[PAGE_SHIFT +: PIDX_W];
  assign area_hit = (AREA_CNT_W'(area_r) < live) && (addr_r >= lo)
                    && ((ADDR_W+1)'(addr_r) < hi);

  // scan issue side
  assign scan_live  = scan_area_r < live;
  assign sa         = scan_area_r[AREA_W-1:0];
  assign su         = usable[sa];
  assign scan_issue = scan_live && (scan_word_r < word_count(su));
  assign rem        = su - PAGES_W'({scan_word_r[WORD_W-1:0], BIT_W'(0)});
  assign issue_mask = (rem >= PAGES_W'(WORD_BITS)) ? '1
                      : ((WORD_BITS'(1) << rem[BIT_W-1:0]) - WORD_BITS'(1));

  // scan test side
  assign q_eff      = q_vld_r ? mem_q_r : '0;
  assign free_vec   = ~q_eff & pend_mask_r;
  assign scan_found = pend_r && (|free_vec);

  always_comb begin
    ffs = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        ffs = BIT_W'(i);
      end
    end
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {sa, scan_word_r[WORD_W-1:0]};
    if (cmd.upd_chk) begin
      rd_en   = area_hit;
      rd_addr = {area_r, chk_idx[PIDX_W-1:BIT_W]};
    end else if (cmd.scan_step) begin
      rd_en   = scan_issue;
    end
  end

  always_comb begin
    wr_en                         = cmd.upd_wr;
    wr_addr                       = {area_r, upd_idx_r[PIDX_W-1:BIT_W]};
    wdata                         = q_eff;
    wdata[upd_idx_r[BIT_W-1:0]]   = mark_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      q_vld_r <= vld_r[rd_addr];
    end
  end

  // a word never written reads as all pages free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r      <= '0;
      hit_r       <= 1'b0;
      scan_area_r <= '0;
      scan_word_r <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        area_r      <= '0;
        hit_r       <= 1'b0;
        scan_area_r <= '0;
        scan_word_r <= '0;
        pend_r      <= 1'b0;
      end
      if (cmd.upd_chk && area_hit) begin
        hit_r <= 1'b1;
      end
      if (cmd.upd_next) begin
        area_r <= area_r + AREA_W'(1);
      end
      if (cmd.scan_step) begin
        pend_r <= scan_issue;
        if (scan_live) begin
          if (scan_issue) begin
            scan_word_r <= scan_word_r + NWORD_W'(1);
          end else begin
            scan_area_r <= scan_area_r + AREA_CNT_W'(1);
            scan_word_r <= '0;
          end
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      addr_r <= in_addr;
      mark_r <= (in_cmd == CMD_MARK);
    end
    if (cmd.upd_chk) begin
      upd_idx_r <= chk_idx;
    end
    if (cmd.scan_step && scan_issue) begin
      pend_area_r <= sa;
      pend_word_r <= scan_word_r[WORD_W-1:0];
      pend_mask_r <= issue_mask;
    end
    if (cmd.scan_step && scan_found) begin
      found_area_r <= pend_area_r;
      found_idx_r  <= {pend_word_r, ffs};
    end
    if (cmd.set_res_upd) begin
      res_status_r <= hit_r ? ST_UPDATED : ST_OUTSIDE;
      res_addr_r   <= '0;
    end
    if (cmd.set_res_none) begin
      res_status_r <= ST_NONE;
      res_addr_r   <= '0;
    end
    if (cmd.calc_addr) begin
      res_status_r <= ST_FOUND;
      res_addr_r   <= cfg.base[found_area_r] + ADDR_W'({found_idx_r, PAGE_SHIFT'(0)});
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_page_addr = out_addr_r;

  assign st.in_find    = (in_cmd != CMD_MARK) && (in_cmd != CMD_FREE);
  assign st.area_hit   = area_hit;
  assign st.area_last  = (area_r == AREA_W'(AREAS - 1));
  assign st.scan_found = scan_found;
  assign st.scan_end   = !pend_r && !scan_live;
  assign st.out_free   = !out_valid_r || out_ready;

endmodule

### src/bitmap_page_frame_allocator.sv
// top level of the bitmap page frame allocator
//
// in_req carries commands (mark, free, find) with a physical address; out_rsp
// returns exactly one result per command: a status and, for a find, the page
// address. Both are valid/ready channels; a transfer happens when both are high.
// The cfg_ apb port sets the area count and each area's base and page count;
// write it only while no command is in flight.
// One command is worked on at a time. A mark or free does one check per area plus
// a read-modify-write of the bitmap word for each area that holds the address.
// A find reads one 32-page bitmap word per cycle from the bitmap memory, area
// by area, over up to 4096 pages per area, and stops at the first free page.
// The result sits in an output register; a new command is taken while it waits,
// and a stalled receiver only holds the block once the next result is ready.
// Reset clears the configuration and marks every page free at once, with no
// clearing pass.
module bitmap_page_frame_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  bpfa_req_if.sink                     in_req,
  bpfa_rsp_if.source                   out_rsp,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [bpfa_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [bpfa_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [bpfa_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import bpfa_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t st;

  bpfa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  bpfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  bpfa_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_cmd        (in_req.cmd),
    .in_addr       (in_req.addr),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_rsp.valid),
    .out_ready     (out_rsp.ready),
    .out_status    (out_rsp.status),
    .out_page_addr (out_rsp.page_addr)
  );

endmodule
